[hw/rtl/mco_pkg.sv]
// ----------------------------------------------------------------------------
// mco_pkg
// Shared codes and handshake types for the matrix chain order cost unit.
// ----------------------------------------------------------------------------
package mco_pkg;

  // Status codes carried on the result word
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SAT      = 2'd1;
  localparam logic [1:0] ST_TOO_MANY = 2'd2;

  // Where the result word takes its cost from
  typedef enum logic [1:0] {
    RES_FILL = 2'd0,
    RES_ZERO = 2'd1,
    RES_OVF  = 2'd2
  } mco_res_sel_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic         load_we;
    logic         issue;
    logic         first_k;
    logic         last_k;
    logic         finish;
    mco_res_sel_t res_sel;
  } mco_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_busy;
  } mco_stat_t;

endpackage

[hw/rtl/mco_ram.sv]
// ----------------------------------------------------------------------------
// mco_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mco_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register both reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

[hw/rtl/mco_ctrl.sv]
// ----------------------------------------------------------------------------
// mco_ctrl
// Sequencer: loads the dimension list, walks span, row and split point of the
// table fill, drains the pipeline between spans and hands over the result.
// ----------------------------------------------------------------------------
module mco_ctrl import mco_pkg::*; #(
  parameter int MAX_DIMS = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  input  logic                        s_tlast,
  output logic                        s_tready,
  input  mco_stat_t                   stat,
  output mco_cmd_t                    cmd,
  output logic [$clog2(MAX_DIMS)-1:0] load_addr,
  output logic [$clog2(MAX_DIMS)-1:0] rd_i,
  output logic [$clog2(MAX_DIMS)-1:0] rd_j,
  output logic [$clog2(MAX_DIMS)-1:0] rd_k
);

  localparam int IDX_BITS = $clog2(MAX_DIMS);
  localparam int CNT_BITS = $clog2(MAX_DIMS + 1);

  localparam logic [1:0] S_LOAD   = 2'd0;
  localparam logic [1:0] S_FILL   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]          state, state_next;
  logic [CNT_BITS-1:0] dim_count, dim_count_next;
  logic                overflow_seen, overflow_seen_next;
  logic [IDX_BITS-1:0] span, span_next;
  logic [IDX_BITS-1:0] idx_i, idx_i_next;
  logic [IDX_BITS-1:0] idx_k, idx_k_next;
  logic [IDX_BITS-1:0] last_idx, last_idx_next;
  mco_res_sel_t        res_sel, res_sel_next;

  logic [IDX_BITS-1:0] idx_j;
  logic [IDX_BITS-1:0] k_plus;
  logic                full;
  logic                first_k;
  logic                last_k;

  assign idx_j     = idx_i + span;
  assign k_plus    = idx_k + IDX_BITS'(1);
  assign full      = (dim_count == CNT_BITS'(MAX_DIMS));
  assign first_k   = (idx_k == idx_i + IDX_BITS'(1));
  assign last_k    = (k_plus == idx_j);
  assign load_addr = dim_count[IDX_BITS-1:0];
  assign rd_i      = idx_i;
  assign rd_j      = idx_j;
  assign rd_k      = idx_k;
  assign s_tready  = (state == S_LOAD);

  // Next state and commands
  always_comb begin
    state_next         = state;
    dim_count_next     = dim_count;
    overflow_seen_next = overflow_seen;
    span_next          = span;
    idx_i_next         = idx_i;
    idx_k_next         = idx_k;
    last_idx_next      = last_idx;
    res_sel_next       = res_sel;
    cmd                = '0;
    cmd.res_sel        = res_sel;

    unique case (state)
      S_LOAD: begin
        if (s_tvalid) begin
          // store the word, or note that the list has run past the store
          if (!full) begin
            cmd.load_we    = 1'b1;
            dim_count_next = dim_count + CNT_BITS'(1);
          end else begin
            overflow_seen_next = 1'b1;
          end
          if (s_tlast) begin
            dim_count_next     = '0;
            overflow_seen_next = 1'b0;
            last_idx_next      = dim_count[IDX_BITS-1:0];
            span_next          = IDX_BITS'(2);
            idx_i_next         = '0;
            idx_k_next         = IDX_BITS'(1);
            if (overflow_seen || full) begin
              res_sel_next = RES_OVF;
              state_next   = S_FINISH;
            end else if (dim_count <= CNT_BITS'(1)) begin
              res_sel_next = RES_ZERO;
              state_next   = S_FINISH;
            end else begin
              state_next = S_FILL;
            end
          end
        end
      end

      S_FILL: begin
        // issue one split point a cycle
        cmd.issue   = 1'b1;
        cmd.first_k = first_k;
        cmd.last_k  = last_k;
        if (!last_k) begin
          idx_k_next = k_plus;
        end else if (idx_j != last_idx) begin
          idx_i_next = idx_i + IDX_BITS'(1);
          idx_k_next = idx_i + IDX_BITS'(2);
        end else begin
          state_next = S_DRAIN;
        end
      end

      S_DRAIN: begin
        // let the span's results land before the next span reads them
        if (!stat.pipe_busy) begin
          if (span == last_idx) begin
            res_sel_next = RES_FILL;
            state_next   = S_FINISH;
          end else begin
            span_next  = span + IDX_BITS'(1);
            idx_i_next = '0;
            idx_k_next = IDX_BITS'(1);
            state_next = S_FILL;
          end
        end
      end

      S_FINISH: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_LOAD;
        end
      end

      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      dim_count     <= '0;
      overflow_seen <= 1'b0;
      span          <= '0;
      idx_i         <= '0;
      idx_k         <= '0;
      last_idx      <= '0;
      res_sel       <= RES_ZERO;
    end else begin
      state         <= state_next;
      dim_count     <= dim_count_next;
      overflow_seen <= overflow_seen_next;
      span          <= span_next;
      idx_i         <= idx_i_next;
      idx_k         <= idx_k_next;
      last_idx      <= last_idx_next;
      res_sel       <= res_sel_next;
    end
  end

endmodule

[hw/rtl/mco_datapath.sv]
// ----------------------------------------------------------------------------
// mco_datapath
// Dimension store, cost table and the split point pipeline: read, partial
// product and cost sum, full product, candidate and running minimum.
// Holds the result word register.
// ----------------------------------------------------------------------------
module mco_datapath import mco_pkg::*; #(
  parameter int MAX_DIMS  = 64,
  parameter int DIM_BITS  = 10,
  parameter int COST_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst,
  input  mco_cmd_t                            cmd,
  input  logic [$clog2(MAX_DIMS)-1:0]         load_addr,
  input  logic [DIM_BITS-1:0]                 load_dim,
  input  logic [$clog2(MAX_DIMS)-1:0]         rd_i,
  input  logic [$clog2(MAX_DIMS)-1:0]         rd_j,
  input  logic [$clog2(MAX_DIMS)-1:0]         rd_k,
  output mco_stat_t                           stat,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((COST_BITS+7)/8)*8-1:0]      m_tdata,
  output logic [1:0]                          m_tuser
);

  localparam int IDX_BITS  = $clog2(MAX_DIMS);
  localparam int TAB_DEPTH = 1 << (2 * IDX_BITS);
  localparam int P1_BITS   = 2 * DIM_BITS;
  localparam int PR_BITS   = 3 * DIM_BITS;
  localparam int WIDE_BITS = (PR_BITS > COST_BITS) ? PR_BITS : COST_BITS;
  localparam int OUT_W     = ((COST_BITS + 7) / 8) * 8;
  localparam logic [COST_BITS-1:0] COST_TOP = '1;

  // Memory read data
  logic [DIM_BITS-1:0]  dim_i, dim_j, dim_k;
  logic [COST_BITS-1:0] cost_ik, cost_kj;

  // Stage 1: meta alongside the RAM read
  logic                v1, first1, last1;
  logic [IDX_BITS-1:0] wi1, wj1;

  // Stage 2
  logic                 v2, first2, last2;
  logic [IDX_BITS-1:0]  wi2, wj2;
  logic [COST_BITS-1:0] ab2;
  logic [P1_BITS-1:0]   p1_2;
  logic [DIM_BITS-1:0]  dk2;

  // Stage 3
  logic                 v3, first3, last3;
  logic [IDX_BITS-1:0]  wi3, wj3;
  logic [COST_BITS-1:0] ab3;
  logic [COST_BITS-1:0] prod3;

  logic [COST_BITS-1:0] best;
  logic [COST_BITS-1:0] fill_cost;

  // Combinational values between stages
  logic [COST_BITS-1:0] a1, b1;
  logic [COST_BITS:0]   ab_sum;
  logic [COST_BITS-1:0] ab1;
  logic [PR_BITS-1:0]   prod_full;
  logic [WIDE_BITS-1:0] prod_wide;
  logic [COST_BITS-1:0] prod2;
  logic [COST_BITS:0]   cand_sum;
  logic [COST_BITS-1:0] cand;
  logic [COST_BITS-1:0] best_next;
  logic [COST_BITS-1:0] out_cost;
  logic [1:0]           out_status;

  // Dimension store, copy for rows and columns
  mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_DIMS)) u_dim_ij (
    .clk     (clk),
    .we      (cmd.load_we),
    .waddr   (load_addr),
    .wdata   (load_dim),
    .raddr_a (rd_i),
    .rdata_a (dim_i),
    .raddr_b (rd_j),
    .rdata_b (dim_j)
  );

  // Dimension store, copy for the split point
  mco_ram #(.WIDTH(DIM_BITS), .DEPTH(MAX_DIMS)) u_dim_k (
    .clk     (clk),
    .we      (cmd.load_we),
    .waddr   (load_addr),
    .wdata   (load_dim),
    .raddr_a (rd_k),
    .rdata_a (dim_k),
    .raddr_b (rd_k),
    .rdata_b ()
  );

  // Cost table, addressed by row then column
  mco_ram #(.WIDTH(COST_BITS), .DEPTH(TAB_DEPTH)) u_cost (
    .clk     (clk),
    .we      (v3 && last3),
    .waddr   ({wi3, wj3}),
    .wdata   (best_next),
    .raddr_a ({rd_i, rd_k}),
    .rdata_a (cost_ik),
    .raddr_b ({rd_k, rd_j}),
    .rdata_b (cost_kj)
  );

  // Stage 1: spans of one read as zero; saturating sum of the two sub-costs
  always_comb begin
    a1     = first1 ? '0 : cost_ik;
    b1     = last1 ? '0 : cost_kj;
    ab_sum = {1'b0, a1} + {1'b0, b1};
    ab1    = ab_sum[COST_BITS] ? COST_TOP : ab_sum[COST_BITS-1:0];
  end

  // Stage 2: full product, clamped at the top of the cost range
  always_comb begin
    prod_full = p1_2 * dk2;
    prod_wide = WIDE_BITS'(prod_full);
    prod2     = (prod_wide > WIDE_BITS'(COST_TOP)) ? COST_TOP
                                                   : prod_wide[COST_BITS-1:0];
  end

  // Stage 3: candidate and running minimum
  always_comb begin
    cand_sum = {1'b0, ab3} + {1'b0, prod3};
    cand     = cand_sum[COST_BITS] ? COST_TOP : cand_sum[COST_BITS-1:0];
    if (first3 || cand < best) begin
      best_next = cand;
    end else begin
      best_next = best;
    end
  end

  // Pipeline valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    first1 <= cmd.first_k;
    last1  <= cmd.last_k;
    wi1    <= rd_i;
    wj1    <= rd_j;

    first2 <= first1;
    last2  <= last1;
    wi2    <= wi1;
    wj2    <= wj1;
    ab2    <= ab1;
    p1_2   <= P1_BITS'(dim_i) * P1_BITS'(dim_j);
    dk2    <= dim_k;

    first3 <= first2;
    last3  <= last2;
    wi3    <= wi2;
    wj3    <= wj2;
    ab3    <= ab2;
    prod3  <= prod2;

    if (v3) begin
      best <= best_next;
    end
    if (v3 && last3) begin
      fill_cost <= best_next;
    end
  end

  // Pick the result word
  always_comb begin
    unique case (cmd.res_sel)
      RES_FILL: begin
        out_cost   = fill_cost;
        out_status = (fill_cost == COST_TOP) ? ST_SAT : ST_OK;
      end
      RES_ZERO: begin
        out_cost   = '0;
        out_status = ST_OK;
      end
      RES_OVF: begin
        out_cost   = '0;
        out_status = ST_TOO_MANY;
      end
      default: begin
        out_cost   = '0;
        out_status = ST_OK;
      end
    endcase
  end

  // Result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= OUT_W'(out_cost);
      m_tuser <= out_status;
    end
  end

  assign stat.pipe_busy = v1 || v2 || v3;
  assign stat.out_busy  = m_tvalid && !m_tready;

endmodule

[hw/rtl/matrix_chain_order_cost_unit.sv]
// ----------------------------------------------------------------------------
// matrix_chain_order_cost_unit
// Least scalar multiplication count of a matrix chain, by interval dynamic
// programming over a cost table held in RAM.
// ----------------------------------------------------------------------------
// Send the chain's dimensions one word each, tlast on the final one; one word
// is taken per cycle while loading. After the last word the input stalls while
// the table is filled: the fill evaluates one split point per clock through a
// four-stage pipeline fed by the two read ports of the cost table, pausing
// after each span until the pipeline drains. Chains of one or two dimensions,
// and lists longer than MAX_DIMS, skip the fill. The result word holds the cost
// in tdata and the status in tuser (0 ok, 1 saturated, 2 too many dimensions);
// the next list may be loaded while it waits to be taken. No clearing pass
// follows reset.
module matrix_chain_order_cost_unit import mco_pkg::*; #(
  parameter int MAX_DIMS  = 64,
  parameter int DIM_BITS  = 10,
  parameter int COST_BITS = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  // s_tdata: dim
  input  logic [((DIM_BITS+7)/8)*8-1:0]     s_tdata,
  input  logic                              s_tlast,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // m_tdata: min_cost
  output logic [((COST_BITS+7)/8)*8-1:0]    m_tdata,
  // m_tuser: status
  output logic [1:0]                        m_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready
);

  localparam int IDX_BITS = $clog2(MAX_DIMS);

  mco_cmd_t            cmd;
  mco_stat_t           stat;
  logic [IDX_BITS-1:0] load_addr;
  logic [IDX_BITS-1:0] rd_i, rd_j, rd_k;

  // Sequencer
  mco_ctrl #(.MAX_DIMS(MAX_DIMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tlast   (s_tlast),
    .s_tready  (s_tready),
    .stat      (stat),
    .cmd       (cmd),
    .load_addr (load_addr),
    .rd_i      (rd_i),
    .rd_j      (rd_j),
    .rd_k      (rd_k)
  );

  // Stores, pipeline and result register
  mco_datapath #(
    .MAX_DIMS  (MAX_DIMS),
    .DIM_BITS  (DIM_BITS),
    .COST_BITS (COST_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .load_addr (load_addr),
    .load_dim  (s_tdata[DIM_BITS-1:0]),
    .rd_i      (rd_i),
    .rd_j      (rd_j),
    .rd_k      (rd_k),
    .stat      (stat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for matrix_chain_order_cost_unit. Dimension lists go in
// as single words with tlast on the final one. A model of the interval cost
// table predicts each result word (cost and status), and every word taken on
// the output is checked in order against it. Both sides idle at random.
// ----------------------------------------------------------------------------
module testbench import mco_pkg::*; ();

  localparam int          DIM_W      = 10;
  localparam int          COST_W     = 48;
  localparam int          DIM_SLOTS  = 64;
  localparam int          ITEM_GOAL  = 850;
  localparam int          TAIL_WAIT  = 64;
  localparam int unsigned CYCLE_CAP  = 3_000_000;
  localparam logic [63:0] COST_CEIL  = (64'd1 << COST_W) - 64'd1;

  typedef struct {
    logic [DIM_W-1:0] dim;
    logic             last;
    logic             drain;   // hold this word until every result is back
  } dim_word_t;

  typedef struct {
    logic [COST_W-1:0] cost;
    logic [1:0]        status;
  } cost_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_tdata = '0;     // dim
  logic        s_tlast = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] m_tdata;          // min_cost
  logic [1:0]  m_tuser;          // status
  logic        m_tvalid;
  logic        m_tready = 1'b0;

  dim_word_t    dim_words[$];
  cost_result_t awaited_costs[$];

  // chain model state
  logic [DIM_W-1:0] dims_held [DIM_SLOTS];
  logic [63:0]      span_cost [DIM_SLOTS][DIM_SLOTS];
  int unsigned      dims_n = 0;
  bit               spill = 1'b0;

  int unsigned errors = 0;
  int unsigned words_sent = 0;
  int unsigned results_checked = 0;
  int unsigned overflow_lists = 0;
  int unsigned lists_queued = 0;
  int unsigned cycles = 0;

  matrix_chain_order_cost_unit uut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
  );

  always #6 clk = ~clk;

  function automatic logic [63:0] add_clamped(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    if (s < a || s > COST_CEIL) return COST_CEIL;
    return s;
  endfunction

  // Fill the interval table by increasing span; return the whole-chain cost
  function automatic logic [63:0] cheapest_order(input int unsigned n);
    logic [63:0] best, prod, cand;
    int unsigned i, j, k, sp;
    for (i = 0; i < n; i++) begin
      span_cost[i][i] = '0;
      if (i + 1 < n) span_cost[i][i+1] = '0;
    end
    for (sp = 2; sp < n; sp++) begin
      for (i = 0; i + sp < n; i++) begin
        j = i + sp;
        best = COST_CEIL;
        for (k = i + 1; k < j; k++) begin
          prod = 64'(dims_held[i]) * 64'(dims_held[k]) * 64'(dims_held[j]);
          if (prod > COST_CEIL) prod = COST_CEIL;
          cand = add_clamped(add_clamped(span_cost[i][k], span_cost[k][j]), prod);
          if (cand < best) best = cand;
        end
        span_cost[i][j] = best;
      end
    end
    return span_cost[0][n-1];
  endfunction

  // Absorb one accepted dimension; on tlast work out the result word
  task automatic absorb_dim(input logic [DIM_W-1:0] d, input logic fin);
    cost_result_t r;
    logic [63:0]  c;
    if (dims_n < DIM_SLOTS) begin
      dims_held[dims_n] = d;
      dims_n++;
    end else begin
      spill = 1'b1;
    end
    if (fin) begin
      r.cost   = '0;
      r.status = ST_OK;
      if (spill) begin
        r.status = ST_TOO_MANY;
        overflow_lists++;
      end else begin
        c = cheapest_order(dims_n);
        if (c >= COST_CEIL) begin
          c        = COST_CEIL;
          r.status = ST_SAT;
        end
        r.cost = c[COST_W-1:0];
      end
      awaited_costs.push_back(r);
      dims_n = 0;
      spill  = 1'b0;
    end
  endtask

  // Queue one list; flavour picks how the dimensions are drawn
  task automatic queue_list(input int unsigned len, input int unsigned flavour,
                            input bit drain);
    dim_word_t w;
    int unsigned i;
    for (i = 0; i < len; i++) begin
      case (flavour)
        0: begin
          w.dim = DIM_W'($urandom_range(0, 1023));
        end
        1: begin
          w.dim = '1;
        end
        2: begin
          w.dim = DIM_W'($urandom_range(0, 15));
        end
        default: begin
          case ($urandom_range(0, 3))
            0: w.dim = '0;
            1: w.dim = DIM_W'(1);
            2: w.dim = '1;
            default: w.dim = DIM_W'($urandom_range(0, 1023));
          endcase
        end
      endcase
      w.last  = (i == len - 1);
      w.drain = drain && (i == 0);
      dim_words.push_back(w);
    end
    lists_queued++;
  endtask

  // Queue a list with fixed dimensions
  task automatic queue_fixed(input int d[], input bit drain);
    dim_word_t w;
    int unsigned i;
    for (i = 0; i < d.size(); i++) begin
      w.dim   = DIM_W'(d[i]);
      w.last  = (i == d.size() - 1);
      w.drain = drain && (i == 0);
      dim_words.push_back(w);
    end
    lists_queued++;
  endtask

  // Stimulus, then wait for the last result and report
  initial begin
    int unsigned pick;
    // short chains, extremes and bit patterns
    queue_fixed('{5}, 1'b0);
    queue_fixed('{1023, 0}, 1'b0);
    queue_fixed('{1023, 1023, 1023}, 1'b1);
    queue_fixed('{0, 1023, 0, 1023}, 1'b0);
    queue_fixed('{10, 20, 30, 40, 30}, 1'b0);
    queue_fixed('{1, 1023, 1, 1023, 1}, 1'b1);
    queue_fixed('{682, 341, 1023, 0}, 1'b0);
    // full store, all at the top, then random; then just over the store
    queue_list(DIM_SLOTS, 1, 1'b1);
    queue_list(DIM_SLOTS, 0, 1'b0);
    queue_list(DIM_SLOTS + 1, 0, 1'b0);
    queue_list(DIM_SLOTS - 1, 3, 1'b1);
    // random lists, mostly short so the fill stays cheap
    while (dim_words.size() < ITEM_GOAL) begin
      pick = $urandom_range(0, 99);
      if (pick < 68)
        queue_list($urandom_range(3, 12), $urandom_range(0, 3), $urandom_range(0, 9) == 0);
      else if (pick < 84)
        queue_list($urandom_range(13, 30), $urandom_range(0, 3), 1'b0);
      else if (pick < 96)
        queue_list($urandom_range(1, 2), $urandom_range(0, 3), 1'b0);
      else
        queue_list($urandom_range(DIM_SLOTS + 1, DIM_SLOTS + 12), $urandom_range(0, 3),
                   $urandom_range(0, 1));
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (dim_words.size() != 0 || s_tvalid || awaited_costs.size() != 0)
      @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("Sent %0d dimension words in %0d lists (%0d over the store).",
             words_sent, lists_queued, overflow_lists);
    $display("Checked %0d result words in %0d cycles, %0d mismatches.",
             results_checked, cycles, errors);
    if (errors == 0 && awaited_costs.size() == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  // Driver: bursts of words with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  always @(posedge clk) begin
    dim_word_t w;
    if (rst) begin
      s_tvalid   <= 1'b0;
      s_tlast    <= 1'b0;
      s_tdata    <= '0;
      dims_n     = 0;
      spill      = 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        absorb_dim(s_tdata[DIM_W-1:0], s_tlast);
        words_sent++;
      end
      // load the next word once the slot is free
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (dim_words.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (dim_words[0].drain && awaited_costs.size() != 0) begin
          s_tvalid <= 1'b0;
        end else begin
          w = dim_words.pop_front();
          s_tdata  <= {6'b0, w.dim};
          s_tlast  <= w.last;
          s_tvalid <= 1'b1;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 99) < 35) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // Monitor: stall the result side on its own pattern and check each word
  int unsigned rx_mode = 0;
  int unsigned rx_left = 0;
  always @(posedge clk) begin
    cost_result_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      cycles++;
      if (m_tvalid && m_tready) begin
        results_checked++;
        if (awaited_costs.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, got cost %0d status %0d",
                   $time, m_tdata, m_tuser);
        end else begin
          e = awaited_costs.pop_front();
          if (m_tdata !== e.cost) begin
            errors++;
            $display("%0t: min_cost mismatch, expected %0d, got %0d", $time, e.cost, m_tdata);
          end
          if (m_tuser !== e.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, e.status, m_tuser);
          end
        end
      end
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(1, 40);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= $urandom_range(0, 1);
        2: m_tready <= 1'b0;
        default: m_tready <= (cycles % 3 != 0);
      endcase
    end
  end

  // Give up well past the slowest correct run
  always @(posedge clk) begin
    if (cycles >= CYCLE_CAP) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycles, awaited_costs.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

endmodule

[filelist.f]
hw/rtl/mco_pkg.sv
hw/rtl/mco_ram.sv
hw/rtl/mco_ctrl.sv
hw/rtl/mco_datapath.sv
hw/rtl/matrix_chain_order_cost_unit.sv
verif/testbench.sv
